// ===== rtl/att_pkg.sv =====
package att_pkg;

   localparam int ZFRAC = 24;
   localparam int ZW = 34;
   localparam int ATAN_ENTRIES = 24;

   localparam logic [1:0] CSR_DEADZONE = 2'd0;
   localparam logic [1:0] CSR_FULLSCALE = 2'd1;
   localparam logic [1:0] CSR_MOVE = 2'd2;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic               calibrate;
   } req_type;

   typedef struct packed {
      logic signed [15:0] joy_x;
      logic signed [15:0] joy_y;
      logic               report;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQRT, ST_PRE_X, ST_CORD_X, ST_PRE_Y, ST_CORD_Y,
      ST_POST, ST_JOY_X, ST_DIV_X, ST_JOY_Y, ST_DIV_Y, ST_OUT
   } state_type;

   function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
      logic [ZW-1:0] v;
      begin
         unique case (i)
            5'd0:  v = 34'd754974720;
            5'd1:  v = 34'd445687602;
            5'd2:  v = 34'd235489089;
            5'd3:  v = 34'd119537938;
            5'd4:  v = 34'd60000934;
            5'd5:  v = 34'd30029717;
            5'd6:  v = 34'd15018523;
            5'd7:  v = 34'd7509720;
            5'd8:  v = 34'd3754917;
            5'd9:  v = 34'd1877466;
            5'd10: v = 34'd938734;
            5'd11: v = 34'd469367;
            5'd12: v = 34'd234684;
            5'd13: v = 34'd117342;
            5'd14: v = 34'd58671;
            5'd15: v = 34'd29335;
            5'd16: v = 34'd14668;
            5'd17: v = 34'd7334;
            5'd18: v = 34'd3667;
            5'd19: v = 34'd1833;
            5'd20: v = 34'd917;
            5'd21: v = 34'd458;
            5'd22: v = 34'd229;
            5'd23: v = 34'd115;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== rtl/att_cordic.sv =====
module att_cordic
   import att_pkg::*;
#(
   parameter int W = 44
) (
   input  logic                clock,
   input  logic                start,
   input  logic                step,
   input  logic signed [W-1:0] y_in,
   input  logic signed [W-1:0] x_in,
   input  logic [4:0]          idx,
   output logic signed [ZW-1:0] z_out
);

   logic signed [W-1:0]  x_ff, y_ff, x_in_w, y_in_w, dx, dy;
   logic signed [ZW-1:0] z_ff, z_in_w;
   logic [ZW-1:0]        a;

   always_comb begin
      x_in_w = x_ff;
      y_in_w = y_ff;
      z_in_w = z_ff;
      dx = y_ff >>> idx;
      dy = x_ff >>> idx;
      a = atan_lut(idx);
      if (start) begin
         // fold the left half-plane into the right
         x_in_w = x_in;
         y_in_w = y_in;
         z_in_w = '0;
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_in_w = y_in;
               y_in_w = -x_in;
               z_in_w = ZW'(90) <<< ZFRAC;
            end else begin
               x_in_w = -y_in;
               y_in_w = x_in;
               z_in_w = -(ZW'(90) <<< ZFRAC);
            end
         end
      end else if (step) begin
         if (y_ff >= 0) begin
            x_in_w = x_ff + dx;
            y_in_w = y_ff - dy;
            z_in_w = z_ff + $signed(a);
         end else begin
            x_in_w = x_ff - dx;
            y_in_w = y_ff + dy;
            z_in_w = z_ff - $signed(a);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in_w;
      y_ff <= y_in_w;
      z_ff <= z_in_w;
   end

   assign z_out = z_ff;

endmodule

// ===== rtl/att_sqrt.sv =====
module att_sqrt (
   input  logic        clock,
   input  logic        start,
   input  logic [47:0] n_in,
   output logic [23:0] root,
   output logic        done
);

   logic [47:0] n_ff, n_in_w, res_ff, res_in_w, bit_ff, bit_in_w;
   logic        busy_ff, busy_in;

   always_comb begin
      n_in_w = n_ff;
      res_in_w = res_ff;
      bit_in_w = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         n_in_w = n_in;
         res_in_w = '0;
         bit_in_w = 48'h4000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= res_ff + bit_ff) begin
            n_in_w = n_ff - (res_ff + bit_ff);
            res_in_w = (res_ff >> 1) + bit_ff;
         end else begin
            res_in_w = res_ff >> 1;
         end
         bit_in_w = bit_ff >> 2;
         if (bit_ff[0]) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in_w;
      res_ff <= res_in_w;
      bit_ff <= bit_in_w;
      busy_ff <= busy_in;
   end

   assign root = res_ff[23:0];
   assign done = !busy_ff;

endmodule

// ===== rtl/accel_tilt_to_joystick.sv =====
// Accelerometer tilt to joystick converter.
// req_ channel: one transfer carries a three-axis sample plus a calibrate flag.
// rsp_ channel: one transfer per sample with joy_x (minus pitch), joy_y (minus
// roll, offset removed) and a report flag.
// csr_ port: APB-style, registers dead zone (0x0), full scale (0x4) and report
// threshold (0x8), all in whole degrees; write only while idle.
// Processing: the square root, then the two arctangents on one shared CORDIC
// datapath, then the bit-serial joystick scaling divider for each axis in turn,
// then the output register is loaded and rsp_valid rises.
// Flow: one sample at a time; req_ready is low while a sample is in work and
// while the result waits in the output register.
// Reset: registers return to 10, 80, 2; roll offset and last report clear.
// Receiver stall: the result holds in rsp_ until rsp_ready takes it.
module accel_tilt_to_joystick
   import att_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int CW = 44;

   state_type state_ff, state_in;
   logic [6:0] dz_ff, mv_ff;
   logic [7:0] fs_ff;
   req_type    req_ff;
   logic [4:0] cnt_ff, cnt_in;
   logic signed [17:0] ax_ff, ay_ff, off_ff, lrx_ff, lry_ff;
   logic signed [17:0] xa_ff, ya_ff, xa_in, ya_in;
   rsp_type    rsp_ff;
   logic       rep_ff, rep_in;
   logic       rsp_valid_q;

   // configuration
   logic       wr;
   logic [1:0] ridx;
   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign ridx = paddr[3:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= 7'd10;
         fs_ff <= 8'd80;
         mv_ff <= 7'd2;
      end else if (wr) begin
         unique case (ridx)
            CSR_DEADZONE:  dz_ff <= pwdata[6:0];
            CSR_FULLSCALE: fs_ff <= pwdata[7:0];
            CSR_MOVE:      mv_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         unique case (ridx)
            CSR_DEADZONE:  prdata = {25'd0, dz_ff};
            CSR_FULLSCALE: prdata = {24'd0, fs_ff};
            CSR_MOVE:      prdata = {25'd0, mv_ff};
            default:       prdata = '0;
         endcase
      end
   end

   // square root of (ay^2 + az^2) << 16, squares formed once at acceptance
   logic [31:0] ay2_ff, az2_ff;
   logic [47:0] sq_n;
   logic [23:0] root;
   logic        sq_done, sq_start;
   assign sq_n = {15'd0, {1'b0, ay2_ff} + {1'b0, az2_ff}} << 16;
   att_sqrt u_sqrt (
      .clock(clock), .start(sq_start), .n_in(sq_n), .root(root), .done(sq_done)
   );

   // shared CORDIC
   logic              c_start, c_step;
   logic signed [CW-1:0] c_y, c_x;
   logic signed [ZW-1:0] z;
   att_cordic #(.W(CW)) u_cordic (
      .clock(clock), .start(c_start), .step(c_step), .y_in(c_y), .x_in(c_x),
      .idx(cnt_ff), .z_out(z)
   );

   // round to 8 fraction bits (16 dropped bits, ties up) and negate
   logic signed [ZW-1:0] zr;
   logic signed [17:0]   ang;
   assign zr = (z + ZW'(32768)) >>> 16;
   assign ang = -zr[17:0];

   // joystick divider: q = mag*32767 / (fs<<8), bit serial, 32 quotient bits
   logic [31:0] rem_ff, rem_in, num_ff, num_in;
   logic [31:0] q_ff, q_in;
   logic [16:0] mulmag;
   logic [31:0] den;
   logic [33:0] r2;
   logic [31:0] qr;
   logic [15:0] joy;
   logic        neg_ff, neg_in;
   assign den = {16'd0, (fs_ff == 8'd0 ? 8'd1 : fs_ff), 8'd0};
   always_comb begin
      logic [31:0] rs;
      rs = {rem_ff[30:0], num_ff[31]};
      r2 = {1'b0, rem_ff, 1'b0};
      qr = q_ff + 32'(((r2 > {2'b0, den}) || (r2 == {2'b0, den} && q_ff[0])) ? 1 : 0);
      joy = (qr > 32'd32767) ? 16'd32767 : qr[15:0];
      if (neg_ff) joy = -joy;
      rem_in = rs;
      q_in = {q_ff[30:0], 1'b0};
      num_in = {num_ff[30:0], 1'b0};
      if (rs >= den) begin
         rem_in = rs - den;
         q_in[0] = 1'b1;
      end
   end

   logic signed [17:0] sel;
   logic [17:0] mag;
   logic signed [18:0] dx, dy;
   logic [18:0] adx, ady;
   always_comb begin
      sel = (state_ff == ST_JOY_X) ? xa_ff : ya_ff;
      mag = sel[17] ? 18'(-sel) : 18'(sel);
      mulmag = mag[16:0];
      dx = {xa_ff[17], xa_ff} - {lrx_ff[17], lrx_ff};
      dy = {ya_ff[17], ya_ff} - {lry_ff[17], lry_ff};
      adx = dx[18] ? 19'(-dx) : 19'(dx);
      ady = dy[18] ? 19'(-dy) : 19'(dy);
   end

   logic signed [17:0] yo, dzv;
   assign dzv = {3'd0, dz_ff, 8'd0};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sq_start = 1'b0;
      c_start = 1'b0;
      c_step = 1'b0;
      c_x = '0;
      c_y = '0;
      xa_in = xa_ff;
      ya_in = ya_ff;
      rep_in = rep_ff;
      neg_in = neg_ff;
      yo = ya_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_SQRT;
         ST_SQRT: begin
            sq_start = 1'b1;
            state_in = ST_PRE_X;
         end
         ST_PRE_X: if (sq_done) begin
            c_start = 1'b1;
            c_y = CW'(ax_ff) <<< 8;
            c_x = CW'({1'b0, root});
            cnt_in = '0;
            state_in = ST_CORD_X;
         end
         ST_CORD_X: begin
            c_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(NSTEPS - 1)) begin
               state_in = ST_PRE_Y;
            end
         end
         ST_PRE_Y: begin
            // an all-zero vector gives angle zero
            xa_in = (ax_ff == 0 && root == 0) ? '0 : ang;
            c_start = 1'b1;
            c_y = CW'(ay_ff) <<< 8;
            c_x = CW'(req_ff.accel_z) <<< 8;
            cnt_in = '0;
            state_in = ST_CORD_Y;
         end
         ST_CORD_Y: begin
            c_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(NSTEPS - 1)) state_in = ST_POST;
         end
         ST_POST: begin
            yo = (ay_ff == 0 && req_ff.accel_z == 0) ? '0 : ang;
            if (req_ff.calibrate) yo = '0;
            else yo = yo - off_ff;
            ya_in = ((yo[17] ? -yo : yo) < dzv) ? '0 : yo;
            xa_in = ((xa_ff[17] ? -xa_ff : xa_ff) < dzv) ? '0 : xa_ff;
            state_in = ST_JOY_X;
         end
         ST_JOY_X: begin
            neg_in = sel[17];
            rep_in = req_ff.calibrate ||
                     adx >= {4'd0, mv_ff, 8'd0} || ady >= {4'd0, mv_ff, 8'd0};
            cnt_in = '0;
            state_in = ST_DIV_X;
         end
         ST_DIV_X: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = ST_JOY_Y;
         end
         ST_JOY_Y: begin
            neg_in = sel[17];
            cnt_in = '0;
            state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = ST_OUT;
         end
         ST_OUT: if (rsp_valid_q && rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic [31:0] prod;
   assign prod = 32'(mulmag) * 32'd32767;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         off_ff <= '0;
         lrx_ff <= '0;
         lry_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (state_ff == ST_POST && req_ff.calibrate) begin
            off_ff <= (ay_ff == 0 && req_ff.accel_z == 0) ? '0 : ang;
         end
         if (state_ff == ST_JOY_X) begin
            if (req_ff.calibrate || adx >= {4'd0, mv_ff, 8'd0}) lrx_ff <= xa_ff;
            if (req_ff.calibrate || ady >= {4'd0, mv_ff, 8'd0}) lry_ff <= ya_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      xa_ff <= xa_in;
      ya_ff <= ya_in;
      rep_ff <= rep_in;
      neg_ff <= neg_in;
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_data;
         ax_ff <= 18'(req_data.accel_x);
         ay_ff <= 18'(req_data.accel_y);
         ay2_ff <= 32'(req_data.accel_y * req_data.accel_y);
         az2_ff <= 32'(req_data.accel_z * req_data.accel_z);
      end
      // load divider, shift one quotient bit a cycle
      if (state_ff == ST_JOY_X || state_ff == ST_JOY_Y) begin
         num_ff <= prod;
         rem_ff <= '0;
         q_ff <= '0;
      end else if (state_ff == ST_DIV_X || state_ff == ST_DIV_Y) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         q_ff <= q_in;
      end
      if (state_ff == ST_JOY_Y) rsp_ff.joy_x <= joy;
      if (state_ff == ST_DIV_Y && cnt_ff == 5'd31) begin
         rsp_ff.report <= rep_ff;
      end
      if (state_ff == ST_OUT && !rsp_valid_q) rsp_ff.joy_y <= joy;
   end

   // joy_y is captured on the first ST_OUT cycle, once the last quotient bit lands
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_q <= 1'b0;
      else rsp_valid_q <= (state_ff == ST_OUT) && !(rsp_valid_q && rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_q;
   assign rsp_data = rsp_ff;

endmodule

// ===== tb/accel_tilt_to_joystick_test.sv =====
module accel_tilt_to_joystick_test;
   import att_pkg::*;

   localparam int STALL_LIMIT = 4000;   // cycles with no transfer before giving up
   localparam int SETTLE = 150;         // a bit more than one sample's latency

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   accel_tilt_to_joystick uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: registers, roll offset and last reported angles (8 fraction bits)
   int unsigned deadzone_reg, fullscale_reg, move_reg;
   int          roll_zero, shown_x, shown_y;
   rsp_type     joy_pending[$];
   int          mismatches = 0;
   int          samples_sent = 0, joy_checked = 0, reports_seen = 0, calibrations = 0;
   bit          steady = 1'b0;     // when set, neither side idles
   int          quiet_cycles = 0;

   function automatic longint atan_step(int i);
      case (i)
         0:  return 754974720;  1:  return 445687602;  2:  return 235489089;
         3:  return 119537938;  4:  return 60000934;   5:  return 30029717;
         6:  return 15018523;   7:  return 7509720;    8:  return 3754917;
         9:  return 1877466;    10: return 938734;     11: return 469367;
         12: return 234684;     13: return 117342;     14: return 58671;
         default: return 29335;
      endcase
   endfunction

   function automatic longint root_of(longint unsigned n);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return longint'(res);
   endfunction

   // arctangent in degrees, 24 fraction bits, 16 vectoring steps
   function automatic longint arc_deg(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 64'sd90 <<< 24;
         end else begin
            t = x; x = -y; y = t; z = -(64'sd90 <<< 24);
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      return z;
   endfunction

   function automatic int fine_angle(longint z);
      return int'((z + (64'sd1 <<< 15)) >>> 16);
   endfunction

   function automatic logic signed [15:0] stick_value(int a);
      longint unsigned fs, mag, num, den, q, r;
      fs = (fullscale_reg == 0) ? 1 : fullscale_reg;
      mag = (a < 0) ? -a : a;
      num = mag * 32767;
      den = fs << 8;
      q = num / den;
      r = num % den;
      if (2 * r > den || (2 * r == den && q[0])) q++;
      if (q > 32767) q = 32767;
      return (a < 0) ? -16'(q) : 16'(q);
   endfunction

   // Work out the joystick transfer for one accepted sample and advance state
   function automatic rsp_type predict_joystick(req_type s);
      longint ax, ay, az, root;
      int ang_x, ang_y, dz, mv, dxa, dya;
      rsp_type o;
      ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
      root = root_of(longint'(ay * ay + az * az) << 16);
      ang_x = -fine_angle(arc_deg(ax <<< 8, root));
      ang_y = -fine_angle(arc_deg(ay <<< 8, az <<< 8));
      dz = deadzone_reg << 8;
      mv = move_reg << 8;
      o.report = 1'b0;
      if (s.calibrate) roll_zero = ang_y;
      ang_y -= roll_zero;
      if ((ang_x < 0 ? -ang_x : ang_x) < dz) ang_x = 0;
      if ((ang_y < 0 ? -ang_y : ang_y) < dz) ang_y = 0;
      if (s.calibrate) begin
         o.report = 1'b1;
         shown_x = ang_x;
         shown_y = ang_y;
      end else begin
         dxa = ang_x - shown_x;
         dya = ang_y - shown_y;
         if ((dxa < 0 ? -dxa : dxa) >= mv) begin
            shown_x = ang_x;
            o.report = 1'b1;
         end
         if ((dya < 0 ? -dya : dya) >= mv) begin
            shown_y = ang_y;
            o.report = 1'b1;
         end
      end
      o.joy_x = stick_value(ang_x);
      o.joy_y = stick_value(ang_y);
      return o;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s at transfer %0d: got %0d, want %0d",
               field, joy_checked, got, want);
      mismatches++;
   endtask

   // Check each result transfer against the oldest pending prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (joy_pending.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = joy_pending.pop_front();
            if (rsp_data.joy_x !== want.joy_x) report_mismatch("joy_x", rsp_data.joy_x, want.joy_x);
            if (rsp_data.joy_y !== want.joy_y) report_mismatch("joy_y", rsp_data.joy_y, want.joy_y);
            if (rsp_data.report !== want.report)
               report_mismatch("report", rsp_data.report, want.report);
            if (want.report) reports_seen++;
         end
         joy_checked++;
      end
   end

   // Receiver: drop ready at random, except in steady stretches
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 18);
   end

   // Watchdog: any transfer resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL accel_tilt_to_joystick");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Entered and left just after a falling edge
   task automatic send_sample(req_type s);
      if (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      joy_pending.push_back(predict_joystick(s));
      samples_sent++;
      if (s.calibrate) calibrations++;
      @(negedge clock);
   endtask

   task automatic send_axes(int ax, int ay, int az, bit cal);
      req_type s;
      s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az); s.calibrate = cal;
      send_sample(s);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      wait (joy_pending.size() == 0);
      @(negedge clock);
   endtask

   // Write one register: setup then access phase; only while the block is idle
   task automatic write_register(logic [1:0] idx, int unsigned value);
      drain_results();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         CSR_DEADZONE:  deadzone_reg = value & 32'h7f;
         CSR_FULLSCALE: fullscale_reg = value & 32'hff;
         CSR_MOVE:      move_reg = value & 32'h7f;
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic set_registers(int unsigned dz, int unsigned fs, int unsigned mv);
      write_register(CSR_DEADZONE, dz);
      write_register(CSR_FULLSCALE, fs);
      write_register(CSR_MOVE, mv);
   endtask

   function automatic int any_sample();
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int gravity_part();
      return $urandom_range(8000) - 4000;
   endfunction

   // Extremes, zero vector, vertical pitch, half-turn roll, calibration
   task automatic test_directed_samples();
      send_axes(0, 0, 0, 0);
      send_axes(32767, 0, 0, 0);
      send_axes(-32768, 0, 0, 0);
      send_axes(0, 0, -16384, 0);
      send_axes(0, 0, -1, 0);
      send_axes(0, 32767, 0, 0);
      send_axes(0, -32768, 0, 0);
      send_axes(-32768, -32768, -32768, 0);
      send_axes(32767, 32767, 32767, 0);
      send_axes(1, -1, 1, 0);
      send_axes(0, 4000, 16384, 1);
      send_axes(0, 4000, 16384, 0);
      send_axes(0, -4000, 16384, 0);
      send_axes(0, 0, 16384, 1);
      send_axes(200, 100, 16384, 0);
      send_axes(16384, 0, 16384, 0);
   endtask

   // Several register settings including the extremes and a zero full scale
   task automatic test_register_settings();
      int unsigned dz[6] = '{0, 90, 127, 0, 5, 10};
      int unsigned fs[6] = '{1, 180, 255, 0, 30, 80};
      int unsigned mv[6] = '{0, 90, 127, 1, 3, 2};
      for (int k = 0; k < 6; k++) begin
         set_registers(dz[k], fs[k], mv[k]);
         send_axes(0, 0, 0, 0);
         send_axes(32767, -32768, 1, 0);
         for (int n = 0; n < 20; n++)
            send_axes(gravity_part(), gravity_part(), 16384 - $urandom_range(32000),
                      $urandom_range(9) == 0);
      end
   endtask

   // Mostly slow tilt walks (report threshold matters), some full-range noise
   task automatic test_random_samples(int count);
      int ax, ay, az;
      ax = 0; ay = 0; az = 16384;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 25) begin
            send_axes(any_sample(), any_sample(), any_sample(), $urandom_range(7) == 0);
         end else begin
            ax += $urandom_range(1200) - 600;
            ay += $urandom_range(1200) - 600;
            az += $urandom_range(1200) - 600;
            if (ax > 20000 || ax < -20000) ax = 0;
            if (ay > 20000 || ay < -20000) ay = 0;
            if (az > 20000 || az < -20000) az = 16384;
            send_axes(ax, ay, az, $urandom_range(29) == 0);
         end
      end
   endtask

   // Steady stream with no idling on either side, draining all pending predictions after every 20 samples
   task automatic test_backpressure();
      steady = 1'b1;
      for (int n = 0; n < 60; n++) begin
         send_axes(gravity_part(), gravity_part(), 16384, 0);
         if (n % 20 == 19) drain_results();
      end
      steady = 1'b0;
   endtask

   initial begin
      deadzone_reg = 10; fullscale_reg = 80; move_reg = 2;
      roll_zero = 0; shown_x = 0; shown_y = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_samples();
      test_register_settings();
      set_registers(10, 80, 2);
      test_random_samples(300);
      test_backpressure();
      set_registers($urandom_range(20), $urandom_range(180, 20), $urandom_range(6));
      test_random_samples(400);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      $display("%0d samples over several register settings, %0d calibrations", samples_sent,
               calibrations);
      $display("%0d joystick transfers checked, %0d flagged as reports", joy_checked,
               reports_seen);
      if (mismatches == 0) begin
         $display("PASS accel_tilt_to_joystick");
      end else begin
         $display("FAIL accel_tilt_to_joystick");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/att_pkg.sv
rtl/att_cordic.sv
rtl/att_sqrt.sv
rtl/accel_tilt_to_joystick.sv
tb/accel_tilt_to_joystick_test.sv
